### rtl/rti_pkg.sv
// Shared constants for the ray/triangle intersection pipeline.
// No dependencies.
package rti_pkg;

  localparam int CW      = 32;  // coordinate width, signed Q16.16
  localparam int MUL_LAT = 4;   // cycles through rti_mul
  localparam int QBITS   = 34;  // quotient bits kept before saturation
  localparam int DIV_LAT = QBITS + 3;
  localparam int NCFG    = 6;
  localparam int CFG_AW  = 5;

  typedef enum logic [2:0] {
    REG_ORG_X = 3'd0,
    REG_ORG_Y = 3'd1,
    REG_ORG_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5
  } reg_idx_t;

endpackage

### rtl/rti_mul.sv
// Pipelined signed multiplier built from 32x32 partial products.
// Registers magnitudes, products, row sums and result on ce. Uses nothing else.
module rti_mul #(
  parameter int WA = 33,
  parameter int WB = 33
) (
  input  logic                    clk,
  input  logic                    ce,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int NA = (WA + 31) / 32;
  localparam int NB = (WB + 31) / 32;
  localparam int WP = WA + WB;
  localparam int WR = 32 * (NB + 1);
  localparam int WT = 32 * (NA + NB);

  logic signed [WA:0] ax, aa;
  logic signed [WB:0] bx, ba;
  logic [32*NA-1:0]   ma_r;
  logic [32*NB-1:0]   mb_r;
  logic [63:0]        pp_r [NA][NB];
  logic [WR-1:0]      row_c [NA];
  logic [WR-1:0]      row_r [NA];
  logic [WT-1:0]      tot_c;
  logic [WP-1:0]      tm;
  logic [2:0]         sg_r;
  logic signed [WP-1:0] p_r;

  assign ax = {a[WA-1], a};
  assign bx = {b[WB-1], b};
  assign aa = ax[WA] ? -ax : ax;
  assign ba = bx[WB] ? -bx : bx;

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_c[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_c[i] = row_c[i] + (WR'(pp_r[i][j]) << (32 * j));
      end
    end
  end

  always_comb begin
    tot_c = '0;
    for (int i = 0; i < NA; i++) begin
      tot_c = tot_c + (WT'(row_r[i]) << (32 * i));
    end
  end

  assign tm = tot_c[WP-1:0];

  always_ff @(posedge clk) begin
    if (ce) begin
      ma_r <= (32*NA)'($unsigned(aa));
      mb_r <= (32*NB)'($unsigned(ba));
      sg_r <= {sg_r[1:0], a[WA-1] ^ b[WB-1]};
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= ma_r[32*i +: 32] * mb_r[32*j +: 32];
        end
      end
      row_r <= row_c;
      p_r   <= sg_r[2] ? $signed(-tm) : $signed(tm);
    end
  end

  assign p = p_r;

endmodule

### rtl/rti_div.sv
// Restoring quotient unit: floor((2*rn + den) / (2*den)) added to the origin,
// saturated to 32 bits. One quotient bit per stage. Uses rti_pkg.
module rti_div #(
  parameter int WN = 134,
  parameter int WD = 101,
  parameter int QB = rti_pkg::QBITS
) (
  input  logic                         clk,
  input  logic                         ce,
  input  logic signed [WN-1:0]         rn,
  input  logic signed [WD-1:0]         den,
  input  logic signed [rti_pkg::CW-1:0] org,
  output logic signed [rti_pkg::CW-1:0] res
);

  localparam int CW  = rti_pkg::CW;
  localparam int WM  = WN + 2;
  localparam int WDV = WD + 1;
  localparam int WX  = ((WM > WDV + QB) ? WM : WDV + QB) + 1;

  logic signed [WM-1:0] nn;
  logic signed [WX-1:0] nx;
  logic [WX-1:0]        mx;
  logic [WDV-1:0]       dv;
  logic                 ng;

  logic [WX-1:0]  ma_r;
  logic [WDV-1:0] dva_r;
  logic           nga_r;

  logic [WX-1:0]  rem_s [QB+1];
  logic [QB-1:0]  q_s   [QB+1];
  logic [WDV-1:0] dv_s  [QB+1];
  logic           ov_s  [QB+1];
  logic           ng_s  [QB+1];

  logic signed [QB:0]   qs;
  logic signed [QB+1:0] sum;
  logic signed [QB+1:0] smax, smin;
  logic signed [CW-1:0] res_r;

  assign nn = $signed({rn[WN-1], rn, 1'b0}) + $signed({{(WM-WD){den[WD-1]}}, den});
  assign nx = WX'(nn);
  assign dv = {den[WD-2:0], 1'b0} | WDV'(0);
  assign ng = nn[WM-1];
  // negative numerator: floor(n/d) = -ceil(|n|/d)
  assign mx = ng ? $unsigned(-nx + $signed(WX'(dv)) - $signed(WX'(1))) : $unsigned(nx);

  always_ff @(posedge clk) begin
    if (ce) begin
      ma_r     <= mx;
      dva_r    <= dv;
      nga_r    <= ng;
      rem_s[0] <= ma_r;
      q_s[0]   <= '0;
      dv_s[0]  <= dva_r;
      ov_s[0]  <= ma_r >= (WX'(dva_r) << QB);
      ng_s[0]  <= nga_r;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    logic [WX-1:0] sh;
    logic          ge;
    assign sh = WX'(dv_s[s]) << (QB - 1 - s);
    assign ge = rem_s[s] >= sh;
    always_ff @(posedge clk) begin
      if (ce) begin
        rem_s[s+1] <= ge ? rem_s[s] - sh : rem_s[s];
        q_s[s+1]   <= q_s[s] | (QB'(ge) << (QB - 1 - s));
        dv_s[s+1]  <= dv_s[s];
        ov_s[s+1]  <= ov_s[s];
        ng_s[s+1]  <= ng_s[s];
      end
    end
  end

  assign qs   = ng_s[QB] ? -$signed({1'b0, q_s[QB]}) : $signed({1'b0, q_s[QB]});
  assign sum  = $signed((QB+2)'(org)) + $signed((QB+2)'(qs));
  assign smax = $signed({{(QB+3-CW){1'b0}}, {(CW-1){1'b1}}});
  assign smin = $signed({{(QB+3-CW){1'b1}}, {(CW-1){1'b0}}});

  always_ff @(posedge clk) begin
    if (ce) begin
      if (ov_s[QB]) begin
        res_r <= ng_s[QB] ? smin[CW-1:0] : smax[CW-1:0];
      end else if (sum > smax) begin
        res_r <= smax[CW-1:0];
      end else if (sum < smin) begin
        res_r <= smin[CW-1:0];
      end else begin
        res_r <= sum[CW-1:0];
      end
    end
  end

  assign res = res_r;

endmodule

### rtl/ray_triangle_intersection_unit.sv
// Ray versus triangle hit test, one triangle per transfer against a ray held in
// registers. Uses rti_pkg, rti_mul and rti_div.
//
// Accepts one triangle every cycle while the skid register is empty. Between
// an input transfer and its result lie an input stage, three multiplier
// levels each followed by an add stage, the quotient unit (34 quotient steps)
// that places the hit point, and the output register. The two barycentric
// levels run beside the quotient unit. A one-entry skid register takes a
// result that is refused, so in_tready does not depend on out_tready; the
// pipeline holds only while that register is full. Exact wide-integer math:
// one-sided test, no divide for the barycentric check. Hit point coordinates
// are rounded to nearest and saturated, and are all zero on a miss. Ray
// registers must only be written while no triangle is in flight.
module ray_triangle_intersection_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [287:0]             in_tdata,   // v1_x,v1_y,v1_z,v2_x..v2_z,v3_x..v3_z
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [95:0]              out_tdata,  // hit_x, hit_y, hit_z
  output logic                     out_tuser,  // hit
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [rti_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]              cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);

  localparam int CW   = rti_pkg::CW;
  localparam int LM   = rti_pkg::MUL_LAT;
  localparam int WE   = CW + 1;
  localparam int WP1  = 2 * WE;
  localparam int WN   = WP1 + 1;
  localparam int WS   = WP1 + 2;
  localparam int WRN  = CW + WN;
  localparam int WDEN = WRN + 2;
  localparam int WWN  = WE + WN;
  localparam int WNUM = WWN + 2;
  localparam int WSS  = 2 * WS;
  localparam int WD0  = WSS + 1;
  localparam int WWD  = WE + WDEN;
  localparam int WRNU = CW + WNUM;
  localparam int WC   = ((WWD > WRNU) ? WWD : WRNU) + 1;
  localparam int WDD  = WD0 + WDEN;
  localparam int WCE  = WC + WE;
  localparam int WC2  = WCE + 2;
  localparam int WCS  = WC2 + WS;
  localparam int WAB  = WCS + 1;

  // stage times, in cycles after the input transfer
  localparam int T1   = 1;
  localparam int TN   = T1 + LM + 1;
  localparam int TD   = TN + LM + 1;
  localparam int TC   = TD + LM + 1;
  localparam int TC2  = TC + LM + 1;
  localparam int TAB  = TC2 + LM + 1;
  localparam int TOK  = TAB + 1;
  localparam int TQ   = TC + rti_pkg::DIV_LAT;
  localparam int TOUT = TQ + 1;

  localparam int LW   = TC - T1;
  localparam int LS   = TC2 - TN;
  localparam int LDD  = TAB - TC + 1;
  localparam int LMS  = TAB - TD;
  localparam int LDN  = TC - TD;
  localparam int LH   = TQ - TOK;

  // ---------------- configuration ----------------
  logic signed [CW-1:0] cfg_r [rti_pkg::NCFG];
  logic                 cfg_wr;
  rti_pkg::reg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = rti_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rti_pkg::NCFG; i++) cfg_r[i] <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rti_pkg::REG_ORG_X, rti_pkg::REG_ORG_Y, rti_pkg::REG_ORG_Z,
        rti_pkg::REG_DIR_X, rti_pkg::REG_DIR_Y, rti_pkg::REG_DIR_Z: begin
          cfg_r[cfg_paddr[4:2]] <= cfg_pwdata;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      rti_pkg::REG_ORG_X, rti_pkg::REG_ORG_Y, rti_pkg::REG_ORG_Z,
      rti_pkg::REG_DIR_X, rti_pkg::REG_DIR_Y, rti_pkg::REG_DIR_Z: begin
        cfg_prdata = cfg_r[cfg_paddr[4:2]];
      end
      default: cfg_prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  logic            ce;
  logic [TOUT-1:0] vld_r;
  logic            main_vld;
  logic            sk_vld_r;

  assign main_vld   = vld_r[TOUT-1];
  assign ce         = !sk_vld_r;
  assign in_tready  = ce;
  assign out_tvalid = sk_vld_r || main_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[TOUT-2:0], in_tvalid};
    end
  end

  // skid entry holds the older result while the pipeline is stopped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sk_vld_r <= 1'b0;
    end else if (sk_vld_r) begin
      if (out_tready) sk_vld_r <= 1'b0;
    end else if (main_vld && !out_tready) begin
      sk_vld_r <= 1'b1;
    end
  end

  // ---------------- edge vectors ----------------
  logic signed [WE-1:0] e2_r [3], e3_r [3], w_r [3];
  logic signed [WE-1:0] e2_d [LW][3], e3_d [LW][3], w_d [LW][3];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        e2_r[k] <= $signed({in_tdata[32*(3+k)+31], in_tdata[32*(3+k) +: 32]})
                 - $signed({in_tdata[32*k+31], in_tdata[32*k +: 32]});
        e3_r[k] <= $signed({in_tdata[32*(6+k)+31], in_tdata[32*(6+k) +: 32]})
                 - $signed({in_tdata[32*k+31], in_tdata[32*k +: 32]});
        w_r[k]  <= $signed({in_tdata[32*k+31], in_tdata[32*k +: 32]})
                 - $signed({cfg_r[k][CW-1], cfg_r[k]});
      end
      e2_d[0] <= e2_r;
      e3_d[0] <= e3_r;
      w_d[0]  <= w_r;
      for (int j = 1; j < LW; j++) begin
        e2_d[j] <= e2_d[j-1];
        e3_d[j] <= e3_d[j-1];
        w_d[j]  <= w_d[j-1];
      end
    end
  end

  // ---------------- level 1: cross product and edge dots ----------------
  logic signed [WP1-1:0] pa_p [3], pb_p [3], q22_p [3], q33_p [3], q23_p [3];

  for (genvar k = 0; k < 3; k++) begin : g_l1
    rti_mul #(.WA(WE), .WB(WE)) u_pa (
      .clk(clk), .ce(ce), .a(e2_r[(k+1)%3]), .b(e3_r[(k+2)%3]), .p(pa_p[k]));
    rti_mul #(.WA(WE), .WB(WE)) u_pb (
      .clk(clk), .ce(ce), .a(e2_r[(k+2)%3]), .b(e3_r[(k+1)%3]), .p(pb_p[k]));
    rti_mul #(.WA(WE), .WB(WE)) u_q22 (
      .clk(clk), .ce(ce), .a(e2_r[k]), .b(e2_r[k]), .p(q22_p[k]));
    rti_mul #(.WA(WE), .WB(WE)) u_q33 (
      .clk(clk), .ce(ce), .a(e3_r[k]), .b(e3_r[k]), .p(q33_p[k]));
    rti_mul #(.WA(WE), .WB(WE)) u_q23 (
      .clk(clk), .ce(ce), .a(e2_r[k]), .b(e3_r[k]), .p(q23_p[k]));
  end

  logic signed [WN-1:0] n_r [3];
  logic signed [WS-1:0] s22_r, s33_r, s23_r;
  logic signed [WS-1:0] s22_d [LS], s33_d [LS], s23_d [LS];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) n_r[k] <= WN'(pa_p[k]) - WN'(pb_p[k]);
      s22_r <= WS'(q22_p[0]) + WS'(q22_p[1]) + WS'(q22_p[2]);
      s33_r <= WS'(q33_p[0]) + WS'(q33_p[1]) + WS'(q33_p[2]);
      s23_r <= WS'(q23_p[0]) + WS'(q23_p[1]) + WS'(q23_p[2]);
      s22_d[0] <= s22_r;
      s33_d[0] <= s33_r;
      s23_d[0] <= s23_r;
      for (int j = 1; j < LS; j++) begin
        s22_d[j] <= s22_d[j-1];
        s33_d[j] <= s33_d[j-1];
        s23_d[j] <= s23_d[j-1];
      end
    end
  end

  // ---------------- level 2: den, num, Gram determinant ----------------
  logic signed [WRN-1:0] rn_p [3];
  logic signed [WWN-1:0] wn_p [3];
  logic signed [WSS-1:0] sa_p, sb_p;

  for (genvar k = 0; k < 3; k++) begin : g_l2
    rti_mul #(.WA(CW), .WB(WN)) u_rn (
      .clk(clk), .ce(ce), .a(cfg_r[3+k]), .b(n_r[k]), .p(rn_p[k]));
    rti_mul #(.WA(WE), .WB(WN)) u_wn (
      .clk(clk), .ce(ce), .a(w_d[TN-T1-1][k]), .b(n_r[k]), .p(wn_p[k]));
  end
  rti_mul #(.WA(WS), .WB(WS)) u_sa (.clk(clk), .ce(ce), .a(s22_r), .b(s33_r), .p(sa_p));
  rti_mul #(.WA(WS), .WB(WS)) u_sb (.clk(clk), .ce(ce), .a(s23_r), .b(s23_r), .p(sb_p));

  logic signed [WDEN-1:0] den_r;
  logic signed [WNUM-1:0] num_r;
  logic signed [WD0-1:0]  d_r;
  logic signed [WDEN-1:0] den_d [LDN];
  logic                   mis;
  logic                   mis_d [LMS];

  // back side, parallel or degenerate (den <= 0), or plane behind origin
  assign mis = den_r[WDEN-1] || (den_r == '0) || num_r[WNUM-1];

  always_ff @(posedge clk) begin
    if (ce) begin
      den_r <= WDEN'(rn_p[0]) + WDEN'(rn_p[1]) + WDEN'(rn_p[2]);
      num_r <= WNUM'(wn_p[0]) + WNUM'(wn_p[1]) + WNUM'(wn_p[2]);
      d_r   <= WD0'(sa_p) - WD0'(sb_p);
      den_d[0] <= den_r;
      for (int j = 1; j < LDN; j++) den_d[j] <= den_d[j-1];
      mis_d[0] <= mis;
      for (int j = 1; j < LMS; j++) mis_d[j] <= mis_d[j-1];
    end
  end

  // ---------------- level 3: C = R*num - W*den, d*den ----------------
  logic signed [WWD-1:0]  wd_p [3];
  logic signed [WRNU-1:0] rnu_p [3];
  logic signed [WDD-1:0]  dd_p;

  for (genvar k = 0; k < 3; k++) begin : g_l3
    rti_mul #(.WA(WE), .WB(WDEN)) u_wd (
      .clk(clk), .ce(ce), .a(w_d[TD-T1-1][k]), .b(den_r), .p(wd_p[k]));
    rti_mul #(.WA(CW), .WB(WNUM)) u_rnu (
      .clk(clk), .ce(ce), .a(cfg_r[3+k]), .b(num_r), .p(rnu_p[k]));
  end
  rti_mul #(.WA(WD0), .WB(WDEN)) u_dd (.clk(clk), .ce(ce), .a(d_r), .b(den_r), .p(dd_p));

  logic signed [WC-1:0]   c_r [3];
  logic signed [WRNU-1:0] rnu_r [3];
  logic signed [WDD-1:0]  dd_d [LDD];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        c_r[k]   <= WC'(rnu_p[k]) - WC'(wd_p[k]);
        rnu_r[k] <= rnu_p[k];
      end
      dd_d[0] <= dd_p;
      for (int j = 1; j < LDD; j++) dd_d[j] <= dd_d[j-1];
    end
  end

  // ---------------- level 4: C.E2, C.E3 ----------------
  logic signed [WCE-1:0] ce2_p [3], ce3_p [3];

  for (genvar k = 0; k < 3; k++) begin : g_l4
    rti_mul #(.WA(WC), .WB(WE)) u_ce2 (
      .clk(clk), .ce(ce), .a(c_r[k]), .b(e2_d[TC-T1-1][k]), .p(ce2_p[k]));
    rti_mul #(.WA(WC), .WB(WE)) u_ce3 (
      .clk(clk), .ce(ce), .a(c_r[k]), .b(e3_d[TC-T1-1][k]), .p(ce3_p[k]));
  end

  logic signed [WC2-1:0] c2_r, c3_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      c2_r <= WC2'(ce2_p[0]) + WC2'(ce2_p[1]) + WC2'(ce2_p[2]);
      c3_r <= WC2'(ce3_p[0]) + WC2'(ce3_p[1]) + WC2'(ce3_p[2]);
    end
  end

  // ---------------- level 5: barycentric numerators ----------------
  logic signed [WCS-1:0] m1_p, m2_p, m3_p, m4_p;

  rti_mul #(.WA(WC2), .WB(WS)) u_m1 (
    .clk(clk), .ce(ce), .a(c2_r), .b(s33_d[LS-1]), .p(m1_p));
  rti_mul #(.WA(WC2), .WB(WS)) u_m2 (
    .clk(clk), .ce(ce), .a(c3_r), .b(s23_d[LS-1]), .p(m2_p));
  rti_mul #(.WA(WC2), .WB(WS)) u_m3 (
    .clk(clk), .ce(ce), .a(c3_r), .b(s22_d[LS-1]), .p(m3_p));
  rti_mul #(.WA(WC2), .WB(WS)) u_m4 (
    .clk(clk), .ce(ce), .a(c2_r), .b(s23_d[LS-1]), .p(m4_p));

  logic signed [WAB-1:0]   a_r, b_r;
  logic signed [WAB:0]     ab;
  logic signed [WAB+1:0]   slack;
  logic                    ok_r;
  logic                    hit_d [LH];

  assign ab    = (WAB+1)'(a_r) + (WAB+1)'(b_r);
  assign slack = (WAB+2)'(dd_d[LDD-1]) - (WAB+2)'(ab);

  always_ff @(posedge clk) begin
    if (ce) begin
      a_r  <= WAB'(m1_p) - WAB'(m2_p);
      b_r  <= WAB'(m3_p) - WAB'(m4_p);
      ok_r <= !mis_d[LMS-1] && !a_r[WAB-1] && !b_r[WAB-1] && !slack[WAB+1];
      hit_d[0] <= ok_r;
      for (int j = 1; j < LH; j++) hit_d[j] <= hit_d[j-1];
    end
  end

  // ---------------- hit point ----------------
  logic signed [CW-1:0] pt [3];

  for (genvar k = 0; k < 3; k++) begin : g_pt
    rti_div #(.WN(WRNU), .WD(WDEN), .QB(rti_pkg::QBITS)) u_div (
      .clk(clk), .ce(ce), .rn(rnu_r[k]), .den(den_d[LDN-1]), .org(cfg_r[k]),
      .res(pt[k]));
  end

  logic                 out_hit_r;
  logic signed [CW-1:0] out_x_r, out_y_r, out_z_r;
  logic                 sk_hit_r;
  logic [95:0]          sk_pt_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      out_hit_r <= hit_d[LH-1];
      out_x_r   <= hit_d[LH-1] ? pt[0] : '0;
      out_y_r   <= hit_d[LH-1] ? pt[1] : '0;
      out_z_r   <= hit_d[LH-1] ? pt[2] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!sk_vld_r) begin
      sk_hit_r <= out_hit_r;
      sk_pt_r  <= {out_z_r, out_y_r, out_x_r};
    end
  end

  assign out_tuser = sk_vld_r ? sk_hit_r : out_hit_r;
  assign out_tdata = sk_vld_r ? sk_pt_r : {out_z_r, out_y_r, out_x_r};

`ifndef ASSERT_OFF
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss result carries a nonzero point");

  a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled without a pending result");

  a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !ce |=> $stable(vld_r))
    else $error("pipeline moved during a stall");
`endif

endmodule

### test/tb_ray_triangle_intersection_unit.sv
// Self-checking bench for ray_triangle_intersection_unit: random and directed
// triangles against several ray settings, with an exact wide-integer predictor.
// Depends on rti_pkg and the RTL of the unit only.
module tb_ray_triangle_intersection_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [31:0]  coord_t;
  typedef logic signed [255:0] wide_t;
  typedef struct { coord_t v[9]; } tri_t;
  typedef struct { logic hit; coord_t x, y, z; } hit_pt_t;

  localparam coord_t ONE    = 32'sh0001_0000;
  localparam coord_t CMAX   = 32'sh7fff_ffff;
  localparam coord_t CMIN   = 32'sh8000_0000;
  localparam int     DRAIN  = 80;
  localparam int     LIMIT  = 200000;
  localparam int     AW     = rti_pkg::CFG_AW;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [287:0] in_tdata = '0;     // v1_x,v1_y,v1_z,v2_x,v2_y,v2_z,v3_x,v3_y,v3_z
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [95:0] out_tdata;          // hit_x, hit_y, hit_z
  logic out_tuser;                 // hit
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  ray_triangle_intersection_unit dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  coord_t  ray_regs[rti_pkg::NCFG];
  tri_t    tri_q[$];
  hit_pt_t hit_q[$];
  tri_t    cur_tri;
  int      in_gap, out_gap, n_fail, n_hits, n_checked, cycles;
  bit      calm, ray_tame;

  // Exact plane/barycentric test; results wrap at 256 bits.
  function automatic hit_pt_t trace_triangle(tri_t t);
    wide_t p1[3], o[3], e2[3], e3[3], w[3], rd[3], n[3], c[3];
    wide_t den, num, s22, s33, s23, c2, c3, a, b, dd, nn, dv, q, s;
    coord_t pt[3];
    hit_pt_t r;
    r = '{1'b0, 32'sd0, 32'sd0, 32'sd0};
    for (int k = 0; k < 3; k++) begin
      p1[k] = t.v[k];
      o[k]  = ray_regs[k];
      rd[k] = ray_regs[3+k];
      e2[k] = t.v[3+k];
      e2[k] = e2[k] - p1[k];
      e3[k] = t.v[6+k];
      e3[k] = e3[k] - p1[k];
      w[k]  = p1[k] - o[k];
    end
    n[0] = e2[1]*e3[2] - e2[2]*e3[1];
    n[1] = e2[2]*e3[0] - e2[0]*e3[2];
    n[2] = e2[0]*e3[1] - e2[1]*e3[0];
    if (n[0] == 0 && n[1] == 0 && n[2] == 0) return r;
    den = rd[0]*n[0] + rd[1]*n[1] + rd[2]*n[2];
    if (den <= 0) return r;
    num = w[0]*n[0] + w[1]*n[1] + w[2]*n[2];
    if (num < 0) return r;
    for (int k = 0; k < 3; k++) c[k] = -w[k]*den + rd[k]*num;
    s22 = e2[0]*e2[0] + e2[1]*e2[1] + e2[2]*e2[2];
    s33 = e3[0]*e3[0] + e3[1]*e3[1] + e3[2]*e3[2];
    s23 = e2[0]*e3[0] + e2[1]*e3[1] + e2[2]*e3[2];
    c2  = c[0]*e2[0] + c[1]*e2[1] + c[2]*e2[2];
    c3  = c[0]*e3[0] + c[1]*e3[1] + c[2]*e3[2];
    a   = c2*s33 - c3*s23;
    b   = c3*s22 - c2*s23;
    dd  = (s22*s33 - s23*s23) * den;
    if (a < 0 || b < 0 || dd - (a + b) < 0) return r;
    dv = 2*den;
    for (int k = 0; k < 3; k++) begin
      nn = 2*rd[k]*num + den;
      // floor division, so halves round toward plus infinity
      q = (nn >= 0) ? nn / dv : -((-nn + dv - 1) / dv);
      s = o[k] + q;
      if (s < wide_t'(CMIN)) pt[k] = CMIN;
      else if (s > wide_t'(CMAX)) pt[k] = CMAX;
      else pt[k] = s[31:0];
    end
    r = '{1'b1, pt[0], pt[1], pt[2]};
    return r;
  endfunction

  // Driver: one triangle per transfer, random gaps unless in the calm stretch.
  always @(posedge clk) begin
    logic nv;
    if (rst_n) begin
      nv = in_tvalid;
      if (in_tvalid && in_tready) begin
        hit_q.insert(hit_q.size(), trace_triangle(cur_tri));
        nv = 1'b0;
      end
      if (!nv) begin
        if (in_gap > 0) in_gap--;
        else if (tri_q.size() > 0) begin
          if (!calm && $urandom_range(0, 6) == 0) in_gap = $urandom_range(1, 3);
          else begin
            cur_tri = tri_q.pop_front();
            for (int k = 0; k < 9; k++) in_tdata[32*k +: 32] <= cur_tri.v[k];
            nv = 1'b1;
          end
        end
      end
      in_tvalid <= nv;
    end
  end

  // Monitor: random back-pressure, field-wise check against oldest prediction.
  always @(posedge clk) begin
    hit_pt_t exp_pt;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (hit_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("unexpected result transfer %b %h", out_tuser, out_tdata);
        end else begin
          exp_pt = hit_q.pop_front();
          n_checked++;
          if (exp_pt.hit) n_hits++;
          if (out_tuser !== exp_pt.hit || out_tdata[31:0] !== exp_pt.x ||
              out_tdata[63:32] !== exp_pt.y || out_tdata[95:64] !== exp_pt.z) begin
            n_fail++;
            if (n_fail <= 10)
              $display("mismatch: exp hit=%0b (%0d,%0d,%0d) got hit=%0b (%0d,%0d,%0d)",
                       exp_pt.hit, exp_pt.x, exp_pt.y, exp_pt.z, out_tuser,
                       $signed(out_tdata[31:0]), $signed(out_tdata[63:32]),
                       $signed(out_tdata[95:64]));
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        out_gap = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(rti_pkg::reg_idx_t idx, coord_t val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= AW'(4 * int'(idx));
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    ray_regs[idx] = val;
  endtask

  // Hold off until every triangle sent has been answered and the pipe is empty.
  // Sampled between edges so the driver's updates have settled.
  task automatic drain();
    @(posedge clk);
    do @(negedge clk);
    while (tri_q.size() > 0 || in_tvalid || hit_q.size() > 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_ray(coord_t ox, coord_t oy, coord_t oz,
                         coord_t dx, coord_t dy, coord_t dz, bit tame);
    drain();
    write_reg(rti_pkg::REG_ORG_X, ox);
    write_reg(rti_pkg::REG_ORG_Y, oy);
    write_reg(rti_pkg::REG_ORG_Z, oz);
    write_reg(rti_pkg::REG_DIR_X, dx);
    write_reg(rti_pkg::REG_DIR_Y, dy);
    write_reg(rti_pkg::REG_DIR_Z, dz);
    ray_tame = tame;
  endtask

  task automatic add_tri(coord_t a0, coord_t a1, coord_t a2, coord_t b0, coord_t b1,
                         coord_t b2, coord_t c0, coord_t c1, coord_t c2);
    tri_t t;
    t.v = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
    tri_q.insert(tri_q.size(), t);
  endtask

  // Mostly triangles around a point on the ray when the ray is tame, some wild or flat ones.
  task automatic add_random_tri();
    tri_t t;
    coord_t ofs[6], tmp;
    int sel, kk;
    sel = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) t.v[k] = $urandom();
    if (ray_tame && sel < 7) begin
      kk = $urandom_range(0, 6);
      for (int k = 0; k < 6; k++) ofs[k] = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      for (int k = 0; k < 3; k++) begin
        tmp = ray_regs[k] + ray_regs[3+k] * kk;
        t.v[k]   = tmp + ofs[k];
        t.v[3+k] = tmp + ofs[3+k];
        t.v[6+k] = tmp - ofs[k] - ofs[3+k] + $signed($urandom_range(0, 64)) - 32;
      end
      if ($urandom_range(0, 3) == 0)
        for (int k = 3; k < 6; k++) begin
          tmp = t.v[k];
          t.v[k] = t.v[k+3];
          t.v[k+3] = tmp;
        end
    end else if (sel == 7) begin
      for (int k = 3; k < 6; k++) t.v[k] = t.v[k-3];
    end else if (sel == 8) begin
      for (int k = 0; k < 9; k++) t.v[k] = $urandom_range(0, 1) ? CMAX : CMIN;
    end
    tri_q.insert(tri_q.size(), t);
  endtask

  task automatic random_ray();
    coord_t r[6];
    for (int k = 0; k < 3; k++) begin
      r[k]   = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      r[3+k] = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    end
    set_ray(r[0], r[1], r[2], r[3], r[4], r[5], 1'b1);
  endtask

  initial begin
    foreach (ray_regs[k]) ray_regs[k] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset ray has zero direction: everything misses
    for (int k = 0; k < 10; k++) add_random_tri();

    set_ray(0, 0, 0, 0, 0, ONE, 1'b1);
    add_tri(-ONE, -ONE, 5*ONE, ONE, -ONE, 5*ONE, -ONE, ONE, 5*ONE);   // front hit
    add_tri(-ONE, -ONE, 5*ONE, -ONE, ONE, 5*ONE, ONE, -ONE, 5*ONE);   // back side
    add_tri(-ONE, -ONE, -5*ONE, ONE, -ONE, -5*ONE, -ONE, ONE, -5*ONE); // behind origin
    add_tri(-ONE, -ONE, 0, ONE, -ONE, 0, -ONE, ONE, 0);               // origin on plane
    add_tri(0, 0, 3*ONE, ONE, 0, 3*ONE, 0, ONE, 3*ONE);               // hit at a vertex
    add_tri(-ONE, 0, 2*ONE, ONE, 0, 2*ONE, 0, ONE, 2*ONE);            // hit on an edge
    add_tri(ONE, ONE, 5*ONE, 2*ONE, ONE, 5*ONE, ONE, 2*ONE, 5*ONE);   // plane hit, outside
    add_tri(-ONE, -ONE, ONE, ONE, -ONE, 2*ONE, -ONE, ONE, 3*ONE);     // tilted, odd point
    add_tri(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE);             // degenerate point
    add_tri(0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE);             // collinear
    add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_tri(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN);
    add_tri(CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX);
    add_tri(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX);

    set_ray(0, 0, 0, ONE, 0, 0, 1'b1);                                // parallel to z planes
    add_tri(-ONE, -ONE, 5*ONE, ONE, -ONE, 5*ONE, -ONE, ONE, 5*ONE);
    add_tri(ONE, -ONE, -ONE, ONE, -ONE, ONE, ONE, ONE, -ONE);

    set_ray(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1'b0);
    add_tri(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN);
    add_tri(CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN);
    for (int k = 0; k < 40; k++) add_random_tri();

    set_ray(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1'b0);
    add_tri(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN);
    for (int k = 0; k < 40; k++) add_random_tri();

    set_ray($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), 1'b0);
    for (int k = 0; k < 60; k++) add_random_tri();

    for (int p = 0; p < 6; p++) begin
      random_ray();
      if (p == 5) calm = 1'b1;
      for (int k = 0; k < 120; k++) add_random_tri();
    end

    drain();
    $display("checked %0d triangle results (%0d hits) over 11 ray settings, %0d cycles",
             n_checked, n_hits, cycles);
    if (n_fail == 0 && hit_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results never seen", n_fail, hit_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
